// ===== src/periodic_task_tick_scheduler_macros.svh =====
// Assertion macros for the checker of the tick scheduler.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PTTS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PTTS_NEVER(name, clk, rst, cond, msg) \
   `PTTS_ASSERT(name, clk, rst, !(cond), msg)

`endif

// ===== src/ptts_pkg.sv =====
package ptts_pkg;

   // Table geometry
   localparam int TASK_SLOTS = 8;
   localparam int COUNT_BITS = 16;
   localparam int SLOT_BITS  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   // Walk counter must also hold TASK_SLOTS itself
   localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

   typedef enum logic [2:0] {
      MODE_CREATE  = 3'd0,
      MODE_DELETE  = 3'd1,
      MODE_SUSPEND = 3'd2,
      MODE_RESUME  = 3'd3,
      MODE_TICK    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      mode_type    mode;
      logic [2:0]  slot;
      logic [15:0] period;
      logic [15:0] first_delay;
   } req_type;

   typedef struct packed {
      logic [2:0] due_slot;
      logic       last;
   } rsp_type;

   // One table entry: reload period and running countdown
   typedef struct packed {
      logic [COUNT_BITS-1:0] reload;
      logic [COUNT_BITS-1:0] countdown;
   } entry_type;

endpackage

// ===== src/ptts_ram.sv =====
module ptts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/periodic_task_tick_scheduler.sv =====
// Create, delete, suspend and resume words complete while idle; busy stays low.
// A tick word holds busy through the walk and the flush: the
// walk reads one table entry a cycle from the registered-read RAM, then flushes.
// Due slots leave in slot order, each in the cycle that the next due slot is found,
// the final one with last set in the flush cycle; the receiver cannot stall.
// Synchronous reset empties every slot; the countdown table needs no clearing.
module periodic_task_tick_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptts_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ptts_pkg::rsp_type rsp_data
);

   localparam int EW = $bits(ptts_pkg::entry_type);

   ptts_pkg::state_type                state_ff, state_in;
   logic [ptts_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [ptts_pkg::SLOT_BITS-1:0]     proc_slot_ff, proc_slot_in;
   logic                               pend_vld_ff, pend_vld_in;
   logic [ptts_pkg::SLOT_BITS-1:0]     pend_slot_ff, pend_slot_in;
   logic [ptts_pkg::TASK_SLOTS-1:0]    present_ff, present_in;
   logic [ptts_pkg::TASK_SLOTS-1:0]    suspended_ff, suspended_in;

   logic                               accept;
   logic                               slot_ok;
   logic [ptts_pkg::SLOT_BITS-1:0]     slot_idx;
   logic                               wr_en;
   logic [ptts_pkg::SLOT_BITS-1:0]     wr_addr;
   ptts_pkg::entry_type                wr_entry;
   logic                               rd_en;
   logic [ptts_pkg::SLOT_BITS-1:0]     rd_addr;
   logic [EW-1:0]                      rd_raw;
   ptts_pkg::entry_type                rd_entry;

   ptts_ram #(
      .WIDTH (EW),
      .DEPTH (ptts_pkg::TASK_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = ptts_pkg::entry_type'(rd_raw);
   assign busy     = (state_ff != ptts_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign slot_ok  = int'(req_data.slot) < ptts_pkg::TASK_SLOTS;
   assign slot_idx = ptts_pkg::SLOT_BITS'(req_data.slot);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptts_pkg::ST_IDLE;
         pend_vld_ff  <= 1'b0;
         present_ff   <= '0;
         suspended_ff <= '0;
      end else begin
         state_ff     <= state_in;
         pend_vld_ff  <= pend_vld_in;
         present_ff   <= present_in;
         suspended_ff <= suspended_in;
      end
   end

   // Walk position and pending due slot
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      proc_slot_ff <= proc_slot_in;
      pend_slot_ff <= pend_slot_in;
   end

   // Decode commands, walk the table and hand out due slots
   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      proc_slot_in      = proc_slot_ff;
      pend_vld_in       = pend_vld_ff;
      pend_slot_in      = pend_slot_ff;
      present_in        = present_ff;
      suspended_in      = suspended_ff;
      wr_en             = 1'b0;
      wr_addr           = proc_slot_ff;
      wr_entry.reload   = rd_entry.reload;
      wr_entry.countdown = rd_entry.countdown - ptts_pkg::COUNT_BITS'(1);
      rd_en             = 1'b0;
      rd_addr           = cnt_ff[ptts_pkg::SLOT_BITS-1:0];
      rsp_strobe        = 1'b0;
      rsp_data.due_slot = 3'(pend_slot_ff);
      rsp_data.last     = 1'b0;

      case (state_ff)
         ptts_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  ptts_pkg::MODE_CREATE: begin
                     if (slot_ok) begin
                        wr_en                  = 1'b1;
                        wr_addr                = slot_idx;
                        wr_entry.reload        = ptts_pkg::COUNT_BITS'(req_data.period);
                        wr_entry.countdown     = ptts_pkg::COUNT_BITS'(req_data.first_delay);
                        present_in[slot_idx]   = 1'b1;
                        suspended_in[slot_idx] = 1'b0;
                     end
                  end
                  ptts_pkg::MODE_DELETE: begin
                     if (slot_ok) begin
                        present_in[slot_idx]   = 1'b0;
                        suspended_in[slot_idx] = 1'b0;
                     end
                  end
                  ptts_pkg::MODE_SUSPEND: begin
                     if (slot_ok && present_ff[slot_idx]) begin
                        suspended_in[slot_idx] = 1'b1;
                     end
                  end
                  ptts_pkg::MODE_RESUME: begin
                     if (slot_ok && present_ff[slot_idx]) begin
                        suspended_in[slot_idx] = 1'b0;
                     end
                  end
                  ptts_pkg::MODE_TICK: begin
                     // issue the read of slot 0
                     rd_en        = 1'b1;
                     rd_addr      = '0;
                     proc_slot_in = '0;
                     cnt_in       = ptts_pkg::CNT_W'(1);
                     pend_vld_in  = 1'b0;
                     state_in     = ptts_pkg::ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ptts_pkg::ST_WALK: begin
            // update the entry read last cycle
            if (present_ff[proc_slot_ff] && !suspended_ff[proc_slot_ff]) begin
               wr_en = 1'b1;
               if (rd_entry.countdown == '0) begin
                  wr_entry.countdown = rd_entry.reload;
                  // a later due slot means the pending one is not last
                  rsp_strobe   = pend_vld_ff;
                  pend_vld_in  = 1'b1;
                  pend_slot_in = proc_slot_ff;
               end
            end
            // advance the read side
            if (cnt_ff == ptts_pkg::CNT_W'(ptts_pkg::TASK_SLOTS)) begin
               state_in = ptts_pkg::ST_FLUSH;
            end else begin
               rd_en        = 1'b1;
               proc_slot_in = cnt_ff[ptts_pkg::SLOT_BITS-1:0];
               cnt_in       = cnt_ff + ptts_pkg::CNT_W'(1);
            end
         end

         ptts_pkg::ST_FLUSH: begin
            // release the final due slot
            rsp_strobe    = pend_vld_ff;
            rsp_data.last = 1'b1;
            pend_vld_in   = 1'b0;
            state_in      = ptts_pkg::ST_IDLE;
         end

         default: begin
            state_in = ptts_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/ptts_checker.sv =====
`include "periodic_task_tick_scheduler_macros.svh"

module ptts_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input ptts_pkg::req_type req_data,
   input logic              rsp_strobe,
   input ptts_pkg::rsp_type rsp_data
);

   logic cmd_taken;
   logic tick_taken;
   logic last_out;

   // Flag accepted words by kind and the final due slot
   assign cmd_taken  = start && !busy && (req_data.mode != ptts_pkg::MODE_TICK);
   assign tick_taken = start && !busy && (req_data.mode == ptts_pkg::MODE_TICK);
   assign last_out   = rsp_strobe && rsp_data.last;

   // Slot commands complete at once
   `PTTS_ASSERT(a_cmd_no_busy, clock, reset, cmd_taken |=> !busy, "slot command raised busy")

   // A tick starts a walk
   `PTTS_ASSERT(a_tick_busy, clock, reset, tick_taken |=> busy, "tick did not start a walk")

   // Due slots only appear during a walk
   `PTTS_NEVER(a_rsp_idle, clock, reset, rsp_strobe && !busy, "due slot outside a walk")

   // The final due slot ends the walk
   `PTTS_ASSERT(a_last_ends, clock, reset, last_out |=> !busy, "walk continued after final due slot")

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   // One word waiting to be sent, with the sender's idle odds for it
   typedef struct {
      ptts_pkg::req_type word;
      int unsigned       gap_pct;
      bit                drain;
   } pending_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   ptts_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   ptts_pkg::rsp_type rsp_data;

   pending_word_type  pending_words[$];
   ptts_pkg::rsp_type due_q[$];
   logic              word_taken = 1'b0;
   int unsigned       mismatch_count = 0;

   // Own copy of the task table
   bit          slot_present   [ptts_pkg::TASK_SLOTS];
   bit          slot_suspended [ptts_pkg::TASK_SLOTS];
   logic [15:0] slot_countdown [ptts_pkg::TASK_SLOTS];
   logic [15:0] slot_reload    [ptts_pkg::TASK_SLOTS];

   periodic_task_tick_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Apply one accepted word to the table and queue the due slots it causes
   function automatic void schedule_word(input ptts_pkg::req_type w);
      ptts_pkg::rsp_type hits[$];
      ptts_pkg::rsp_type r;
      if (w.mode == ptts_pkg::MODE_TICK) begin
         for (int s = 0; s < ptts_pkg::TASK_SLOTS; s++) begin
            if (slot_present[s] && !slot_suspended[s]) begin
               if (slot_countdown[s] == 16'd0) begin
                  r.due_slot = s[2:0];
                  r.last     = 1'b0;
                  hits.push_back(r);
                  slot_countdown[s] = slot_reload[s];
               end else begin
                  slot_countdown[s] = slot_countdown[s] - 16'd1;
               end
            end
         end
         if (hits.size() != 0) hits[hits.size() - 1].last = 1'b1;
         foreach (hits[i]) due_q.push_back(hits[i]);
      end else begin
         case (w.mode)
            ptts_pkg::MODE_CREATE: begin
               slot_reload[w.slot]    = w.period;
               slot_countdown[w.slot] = w.first_delay;
               slot_suspended[w.slot] = 1'b0;
               slot_present[w.slot]   = 1'b1;
            end
            ptts_pkg::MODE_DELETE: begin
               slot_present[w.slot]   = 1'b0;
               slot_suspended[w.slot] = 1'b0;
            end
            ptts_pkg::MODE_SUSPEND: begin
               if (slot_present[w.slot]) slot_suspended[w.slot] = 1'b1;
            end
            ptts_pkg::MODE_RESUME: begin
               if (slot_present[w.slot]) slot_suspended[w.slot] = 1'b0;
            end
            default: begin
            end
         endcase
      end
   endfunction

   function automatic ptts_pkg::req_type make_word(input logic [2:0] mode, input int slot,
                                                   input int period, input int delay);
      ptts_pkg::req_type w;
      w.mode        = ptts_pkg::mode_type'(mode);
      w.slot        = slot[2:0];
      w.period      = period[15:0];
      w.first_delay = delay[15:0];
      return w;
   endfunction

   // Mostly small counts so tasks fall due often; now and then full range
   function automatic int random_count();
      int r;
      r = $urandom_range(9);
      if (r < 6) return $urandom_range(5);
      if (r < 8) return $urandom_range(40);
      if (r == 8) return $urandom_range(65535);
      return ($urandom_range(1) == 1) ? 65535 : 0;
   endfunction

   function automatic ptts_pkg::req_type random_word();
      int pick;
      logic [2:0] mode;
      pick = $urandom_range(99);
      if (pick < 45)      mode = ptts_pkg::MODE_TICK;
      else if (pick < 70) mode = ptts_pkg::MODE_CREATE;
      else if (pick < 80) mode = ptts_pkg::MODE_DELETE;
      else if (pick < 89) mode = ptts_pkg::MODE_SUSPEND;
      else if (pick < 97) mode = ptts_pkg::MODE_RESUME;
      else                mode = 3'($urandom_range(7, 5));
      return make_word(mode, $urandom_range(7), random_count(), random_count());
   endfunction

   task automatic push_word(input ptts_pkg::req_type w, input int unsigned gap,
                            input bit drain);
      pending_word_type p;
      p.word    = w;
      p.gap_pct = gap;
      p.drain   = drain;
      pending_words.push_back(p);
   endtask

   // Driver: change inputs on the falling edge, hold a word until taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !word_taken) begin
         start <= 1'b1;
      end else if (pending_words.size() == 0) begin
         start <= 1'b0;
      end else if (pending_words[0].drain && (busy || due_q.size() != 0)) begin
         start <= 1'b0;
      end else if ($urandom_range(99) < pending_words[0].gap_pct) begin
         start <= 1'b0;
      end else begin
         req_data <= pending_words[0].word;
         start    <= 1'b1;
         void'(pending_words.pop_front());
      end
   end

   // Monitor: check results first, then predict from the word taken
   always @(posedge clock) begin
      ptts_pkg::rsp_type want;
      if (reset) begin
         word_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (due_q.size() == 0) begin
               report_mismatch("unexpected due_slot", rsp_data.due_slot, -1);
            end else begin
               want = due_q.pop_front();
               if (rsp_data.due_slot !== want.due_slot)
                  report_mismatch("due_slot", rsp_data.due_slot, want.due_slot);
               if (rsp_data.last !== want.last)
                  report_mismatch("last", rsp_data.last, want.last);
            end
         end
         word_taken <= start && !busy;
         if (start && !busy) schedule_word(req_data);
      end
   end

   // Stimulus and end of run
   initial begin
      int phase_gap[4];
      phase_gap = '{0, 83, 0, 7};

      // Directed: empty tick, extremes, ignored commands, overwrite, full tick
      push_word(make_word(ptts_pkg::MODE_TICK, 0, 0, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_CREATE, 0, 0, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_CREATE, 7, 65535, 65535), 0, 0);
      push_word(make_word(ptts_pkg::MODE_SUSPEND, 5, 1234, 4321), 0, 0);
      push_word(make_word(ptts_pkg::MODE_RESUME, 5, 0, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_DELETE, 6, 65535, 65535), 0, 0);
      push_word(make_word(3'd5, 1, 7, 7), 0, 0);
      push_word(make_word(3'd7, 2, 65535, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_TICK, 7, 65535, 65535), 0, 0);
      push_word(make_word(ptts_pkg::MODE_CREATE, 3, 2, 1), 0, 0);
      push_word(make_word(ptts_pkg::MODE_TICK, 0, 0, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_TICK, 0, 0, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_SUSPEND, 0, 0, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_TICK, 0, 0, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_CREATE, 0, 1, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_RESUME, 3, 0, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_DELETE, 0, 0, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_TICK, 0, 0, 0), 0, 0);
      for (int s = 0; s < ptts_pkg::TASK_SLOTS; s++)
         push_word(make_word(ptts_pkg::MODE_CREATE, s, 0, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_TICK, 0, 0, 0), 0, 0);
      push_word(make_word(ptts_pkg::MODE_TICK, 0, 0, 0), 0, 1);

      // Random: four idling phases, the third now and then holding off until drained
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < 84; i++)
            push_word(random_word(), phase_gap[p], (p == 2) && ($urandom_range(7) == 0));
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Drain: every word taken, every due slot seen, then settle
      while (pending_words.size() != 0 || start) @(negedge clock);
      while (due_q.size() != 0 || busy) @(negedge clock);
      repeat (20) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("[periodic_task_tick_scheduler] OK");
      end else begin
         $display("[periodic_task_tick_scheduler] ERROR");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #5ms;
      $display("[periodic_task_tick_scheduler] ERROR");
      $finish;
   end

endmodule
